FILE: hdl/html_entity_decoder_defines.svh
// ----------------------------------------------------------------------------
// html_entity_decoder_defines
// Assertion macros for the entity decoder top module.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HED_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HED_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Types and constants for the HTML character entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  // Parser modes. The fourth code is unused and behaves as plain text.
  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_NAME   = 2'd1,
    MODE_NUMBER = 2'd2
  } parse_mode_t;

  localparam int          NAME_COUNT     = 5;
  localparam logic [4:0]  ALL_CANDIDATES = 5'h1f;
  localparam logic [2:0]  LENGTH_MAX     = 3'd7;

  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Entity names: amp, lt, gt, quot, apos (padded with zero bytes).
  localparam logic [7:0] NAME_TEXT [NAME_COUNT][4] = '{
    '{8'h61, 8'h6d, 8'h70, 8'h00},
    '{8'h6c, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'h6f, 8'h74},
    '{8'h61, 8'h70, 8'h6f, 8'h73}
  };
  localparam logic [2:0] NAME_LEN  [NAME_COUNT] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
  localparam logic [7:0] NAME_CHAR [NAME_COUNT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

  // Parser state carried from one byte to the next.
  typedef struct packed {
    parse_mode_t mode;
    logic [2:0]  name_length;
    logic [4:0]  candidate_mask;
    logic [7:0]  numeric_value;
    logic        digits_stopped;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    mode:           MODE_PLAIN,
    name_length:    3'd0,
    candidate_mask: ALL_CANDIDATES,
    numeric_value:  8'd0,
    digits_stopped: 1'b0
  };

  // Result of one byte step.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
  } step_result_t;

endpackage

FILE: hdl/hed_step.sv
// ----------------------------------------------------------------------------
// hed_step
// Combinational parser step: next state and the optional decoded word.
// ----------------------------------------------------------------------------
module hed_step
  import hed_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   in_byte,
  input  logic         last_byte,
  output parse_state_t state_next,
  output step_result_t result
);

  logic       is_semi;
  logic       is_digit;
  logic [4:0] keep_mask;
  logic [7:0] named_char;
  logic       named_hit;
  logic [7:0] value_times_ten;

  assign is_semi  = (in_byte == CHAR_SEMI);
  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign value_times_ten = {state.numeric_value[4:0], 3'b000} +
                           {state.numeric_value[6:0], 1'b0};

  // Which entity names still match after this byte.
  always_comb begin
    for (int k = 0; k < NAME_COUNT; k++) begin
      keep_mask[k] = (state.name_length < NAME_LEN[k]) &&
                     (NAME_TEXT[k][state.name_length[1:0]] == in_byte);
    end
  end

  // First surviving name whose length matches the name seen so far.
  always_comb begin
    named_hit  = 1'b0;
    named_char = 8'd0;
    for (int k = 0; k < NAME_COUNT; k++) begin
      if (!named_hit && state.candidate_mask[k] && (state.name_length == NAME_LEN[k])) begin
        named_hit  = 1'b1;
        named_char = NAME_CHAR[k];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state.mode)
      MODE_NAME: begin
        if (is_semi) begin
          state_next = STATE_CLEAR;
        end else begin
          if ((state.name_length == 3'd0) && (in_byte == CHAR_HASH)) begin
            state_next.mode           = MODE_NUMBER;
            state_next.numeric_value  = 8'd0;
            state_next.digits_stopped = 1'b0;
          end else begin
            state_next.candidate_mask = state.candidate_mask & keep_mask;
          end
          if (state.name_length < LENGTH_MAX) begin
            state_next.name_length = state.name_length + 3'd1;
          end
        end
      end
      MODE_NUMBER: begin
        if (is_semi) begin
          state_next = STATE_CLEAR;
        end else if (!state.digits_stopped && is_digit) begin
          state_next.numeric_value = value_times_ten + (in_byte - CHAR_ZERO);
        end else begin
          state_next.digits_stopped = 1'b1;
        end
      end
      default: begin
        if (in_byte == CHAR_AMP) begin
          state_next      = STATE_CLEAR;
          state_next.mode = MODE_NAME;
        end
      end
    endcase
    if (last_byte) begin
      state_next = STATE_CLEAR;
    end
  end

  // Output word.
  always_comb begin
    result.emit = 1'b0;
    result.data = in_byte;
    case (state.mode)
      MODE_NAME: begin
        result.emit = is_semi && named_hit;
        result.data = named_char;
      end
      MODE_NUMBER: begin
        result.emit = is_semi;
        result.data = state.numeric_value;
      end
      default: begin
        result.emit = (in_byte != CHAR_AMP);
        result.data = in_byte;
      end
    endcase
  end

endmodule

FILE: hdl/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder: each byte passes the input register, then the result register.
// Throughput one byte per cycle while the output is not stalled; the parser state updates once per byte.
// Synchronous reset empties both registers and returns the parser to plain text.
// ----------------------------------------------------------------------------
module html_entity_decoder
  import hed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

`include "html_entity_decoder_defines.svh"

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         s1_advance;
  logic         out_free;
  parse_state_t state;
  parse_state_t state_next;
  step_result_t result;

  // The output register can take a word when empty or being emptied.
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_last <= last_byte;
    end
  end

  hed_step u_step (
    .state      (state),
    .in_byte    (s1_byte),
    .last_byte  (s1_last),
    .state_next (state_next),
    .result     (result)
  );

  // Parser state moves on once per byte leaving the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && result.emit;
    end
    if (s1_advance && result.emit) begin
      out_byte <= result.data;
    end
  end

  // Checks on the parser and its coupling to the pipeline.
  `HED_ASSERT_NEXT(a_state_holds_on_stall, clk, rst, (out_valid && !out_ready),
    $stable(state), "parser state changed while the output was stalled")
  `HED_ASSERT_SAME(a_plain_is_clear, clk, rst, (state.mode == MODE_PLAIN),
    ((state.name_length == 3'd0) && (state.candidate_mask == ALL_CANDIDATES)),
    "plain text mode with a stale name")
  `HED_ASSERT_NEXT(a_last_clears, clk, rst, (s1_advance && s1_last),
    (state == STATE_CLEAR), "last byte did not return the parser to reset")

endmodule
